// ----- rtl/gamepad_frame_decoder_top_macros.svh -----
// Assertion macros for the gamepad frame decoder.
// Used by gamepad_frame_decoder_top.sv; expects clk and rst_n in scope.
`ifndef GAMEPAD_FRAME_DECODER_TOP_MACROS_SVH
`define GAMEPAD_FRAME_DECODER_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define GFD_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("gamepad_frame_decoder assertion failed");
`define GFD_ASSERT_NEVER(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("gamepad_frame_decoder forbidden condition seen");
`else
`define GFD_ASSERT(lbl, prop)
`define GFD_ASSERT_NEVER(lbl, cond)
`endif
`endif

// ----- rtl/gfd_pkg.sv -----
// Shared types, constants and functions of the gamepad frame decoder.
// No dependencies; imported by every module of the block.
package gfd_pkg;

    localparam int FRAME_LEN    = 8;
    localparam int PAYLOAD_LEN  = 6;
    localparam int BUTTON_COUNT = 16;
    localparam int BYTE_W       = 8;
    localparam int POS_W        = $clog2(FRAME_LEN);
    localparam int SUM_W        = 11;
    localparam int CHECK_W      = 7;

    localparam logic [BYTE_W-1:0] START_BYTE_RESET = 8'd128;
    localparam logic [BYTE_W-1:0] STICK_CENTER     = 8'd64;

    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    localparam int PADDR_W = 3;
    // register index sits above the byte offset within a 32-bit word
    localparam logic REG_START_BYTE = 1'b0;

    typedef enum logic [1:0] {
        BTN_RELEASED     = 2'd0,
        BTN_PRESS_EDGE   = 2'd1,
        BTN_HELD         = 2'd2,
        BTN_RELEASE_EDGE = 2'd3
    } btn_state_t;

    typedef logic [PAYLOAD_LEN-1:0][BYTE_W-1:0] payload_t;

    typedef struct packed {
        logic     frame_valid;
        payload_t payload;
    } gfd_entry_t;

    typedef struct packed {
        logic               empty;
        logic               full;
        logic [Q_CNT_W-1:0] count;
    } gfd_q_status_t;

    function automatic btn_state_t btn_next(btn_state_t prev, logic pressed);
        logic down_before;
        down_before = (prev == BTN_PRESS_EDGE) || (prev == BTN_HELD);
        if (pressed)
            return down_before ? BTN_HELD : BTN_PRESS_EDGE;
        return down_before ? BTN_RELEASE_EDGE : BTN_RELEASED;
    endfunction

endpackage

// ----- rtl/gfd_front.sv -----
// Front end: finds the start byte, rotates the window and checks the sum.
// Depends on gfd_pkg.
module gfd_front
    import gfd_pkg::*;
(
    input  logic [FRAME_LEN*BYTE_W-1:0] window,
    input  logic [BYTE_W-1:0]           start_byte,
    output gfd_entry_t                  entry
);

    logic [FRAME_LEN-1:0][BYTE_W-1:0] raw;
    logic [FRAME_LEN-1:0][BYTE_W-1:0] frame;
    logic                             found;
    logic [POS_W-1:0]                 pos;
    logic [SUM_W-1:0]                 sum;

    assign raw = window;

    // last matching position wins
    always_comb
    begin
        found = 1'b0;
        pos   = '0;
        for (int i = 0; i < FRAME_LEN; i++)
        begin
            if (raw[i] == start_byte)
            begin
                found = 1'b1;
                pos   = POS_W'(i);
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < FRAME_LEN; i++)
        begin
            frame[i] = raw[POS_W'(pos + POS_W'(i))];
        end
    end

    always_comb
    begin
        sum = '0;
        for (int i = 1; i <= PAYLOAD_LEN; i++)
        begin
            sum = sum + SUM_W'(frame[i]);
        end
    end

    always_comb
    begin
        entry.frame_valid = found && ({1'b0, sum[CHECK_W-1:0]} == frame[FRAME_LEN-1]);
        for (int i = 0; i < PAYLOAD_LEN; i++)
        begin
            entry.payload[i] = frame[i+1];
        end
    end

endmodule

// ----- rtl/gfd_queue.sv -----
// Short queue of classified frames between front and back end.
// Depends on gfd_pkg.
module gfd_queue
    import gfd_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  gfd_entry_t    push_entry,
    input  logic          pop,
    output gfd_entry_t    pop_entry,
    output gfd_q_status_t status
);

    gfd_entry_t         slot_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg;
    logic [Q_PTR_W-1:0] wr_ptr_next;
    logic [Q_PTR_W-1:0] rd_ptr_reg;
    logic [Q_PTR_W-1:0] rd_ptr_next;
    logic [Q_CNT_W-1:0] count_reg;
    logic [Q_CNT_W-1:0] count_next;
    logic               do_push;
    logic               do_pop;

    assign status.count = count_reg;
    assign status.empty = (count_reg == '0);
    assign status.full  = (count_reg == Q_CNT_W'(Q_DEPTH));

    assign do_push = push && !status.full;
    assign do_pop  = pop && !status.empty;

    assign pop_entry = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? Q_PTR_W'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = do_pop  ? Q_PTR_W'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
            count_next = Q_CNT_W'(count_reg + 1'b1);
        else if (do_pop && !do_push)
            count_next = Q_CNT_W'(count_reg - 1'b1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_entry;
    end

endmodule

// ----- rtl/gfd_back.sv -----
// Back end: stores good frames, runs the button edge machines, decodes sticks.
// Depends on gfd_pkg.
module gfd_back
    import gfd_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         entry_ready,
    input  gfd_entry_t                   entry,
    output logic                         pop,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [4*BYTE_W+2*BUTTON_COUNT-1:0] out_data,
    output logic                         out_flag
);

    payload_t   stored_reg;
    payload_t   stored_next;
    btn_state_t hist_reg  [BUTTON_COUNT];
    btn_state_t hist_next [BUTTON_COUNT];
    logic [BUTTON_COUNT-1:0]       word;
    logic [2*BUTTON_COUNT-1:0]     states;
    logic [BYTE_W-1:0]             lx;
    logic [BYTE_W-1:0]             ly;
    logic [BYTE_W-1:0]             rx;
    logic [BYTE_W-1:0]             ry;
    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic [4*BYTE_W+2*BUTTON_COUNT-1:0] out_data_reg;
    logic                          out_flag_reg;

    assign pop = entry_ready && (!out_valid_reg || out_ready);

    always_comb
    begin
        stored_next = (pop && entry.frame_valid) ? entry.payload : stored_reg;
        word        = {stored_next[0], stored_next[1]};
        for (int i = 0; i < BUTTON_COUNT; i++)
        begin
            hist_next[i]      = pop ? btn_next(hist_reg[i], word[i]) : hist_reg[i];
            states[2*i +: 2]  = hist_next[i];
        end
        lx = BYTE_W'(stored_next[2] - STICK_CENTER);
        ly = BYTE_W'(STICK_CENTER - stored_next[3]);
        rx = BYTE_W'(stored_next[4] - STICK_CENTER);
        ry = BYTE_W'(STICK_CENTER - stored_next[5]);
        out_valid_next = pop ? 1'b1 : (out_valid_reg && !out_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stored_reg    <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < BUTTON_COUNT; i++)
            begin
                hist_reg[i] <= BTN_RELEASED;
            end
        end
        else
        begin
            stored_reg    <= stored_next;
            out_valid_reg <= out_valid_next;
            hist_reg      <= hist_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_data_reg <= {states, ry, rx, ly, lx};
            out_flag_reg <= entry.frame_valid;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_flag  = out_flag_reg;

endmodule

// ----- rtl/gamepad_frame_decoder_top.sv -----
// Top level of the gamepad frame decoder: config register, front, queue, back.
// Depends on gfd_pkg, gfd_front, gfd_queue, gfd_back and the assertion macros.
//
//  Channel   Dir  Handshake                     Payload
//  s_axis    in   tvalid/tready                 tdata: raw_byte_0 .. raw_byte_7
//  m_axis    out  tvalid/tready                 tdata: sticks, buttons; tuser: frame_valid
//  apb       in   psel/penable/pwrite/pready    start_byte at byte address 0
//
// One word per cycle sustained while m_axis is not stalled. A word is classified
// in the cycle it is accepted, is written into the four-deep queue, and is then
// loaded into the output register when the back end pops it.
// rst_n is asynchronous: queue empty, stored frame zero, buttons released,
// start byte 128. A stall on m_axis holds the output word; the queue keeps
// taking words until it is full, then s_axis_tready drops.
`include "gamepad_frame_decoder_top_macros.svh"
module gamepad_frame_decoder_top
    import gfd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // slave stream
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [63:0]          s_axis_tdata,  // raw_byte_0 [7:0] .. raw_byte_7 [63:56]
    // master stream
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [63:0]          m_axis_tdata,  // left_x, left_y, right_x, right_y, button_states
    output logic                 m_axis_tuser,  // frame_valid
    // configuration
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [PADDR_W-1:0]   paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    logic [BYTE_W-1:0] start_byte_reg;
    logic [BYTE_W-1:0] start_byte_next;
    logic              cfg_write;
    gfd_entry_t        front_entry;
    gfd_entry_t        pop_entry;
    gfd_q_status_t     q_status;
    logic              pop;
    logic              s_accept;

    // Only the register index bit is decoded; the byte offset is ignored.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready
                       && (paddr[PADDR_W-1] == REG_START_BYTE);
    assign start_byte_next = cfg_write ? pwdata[BYTE_W-1:0] : start_byte_reg;
    assign prdata = (paddr[PADDR_W-1] == REG_START_BYTE) ? {24'd0, start_byte_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            start_byte_reg <= START_BYTE_RESET;
        else
            start_byte_reg <= start_byte_next;
    end

    // Front end is pure logic: classification happens in the acceptance cycle.
    gfd_front u_front
    (
        .window     (s_axis_tdata),
        .start_byte (start_byte_reg),
        .entry      (front_entry)
    );

    assign s_axis_tready = !q_status.full;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    gfd_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (s_accept),
        .push_entry (front_entry),
        .pop        (pop),
        .pop_entry  (pop_entry),
        .status     (q_status)
    );

    // Back end owns all frame state; it pops whenever its output slot frees.
    gfd_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .entry_ready (!q_status.empty),
        .entry       (pop_entry),
        .pop         (pop),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_data    (m_axis_tdata),
        .out_flag    (m_axis_tuser)
    );

    // Queue never holds more than its depth.
    `GFD_ASSERT_NEVER(a_queue_bound, q_status.count > Q_CNT_W'(Q_DEPTH))
    // A good frame taken by the back end shows up flagged on the output.
    `GFD_ASSERT(a_flag_follows, (pop && pop_entry.frame_valid) |=> m_axis_tuser)
    // With nothing queued and the output free, an accepted word passes through the queue and the output register.
    `GFD_ASSERT(a_latency, (s_accept && q_status.empty && !m_axis_tvalid) |=> ##1 m_axis_tvalid)

endmodule
